[sv/crc8fr_pkg.sv]
// ----------------------------------------------------------------------------
// crc8fr_pkg
// shared constants, codes and helpers for the crc-8 checked frame receiver
// ----------------------------------------------------------------------------
package crc8fr_pkg;

  // payload buffer depth and derived widths
  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] SYNC_BYTE = 8'hFA;
  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] LEN_OVERHEAD = 8'h02;
  localparam logic [7:0] MAX_PLEN  = 8'(MAX_PAYLOAD);

  // frame types
  localparam logic [7:0] TYPE_HOST_READY = 8'h00;
  localparam logic [7:0] TYPE_2          = 8'h02;
  localparam logic [7:0] TYPE_3          = 8'h03;
  localparam logic [7:0] TYPE_4          = 8'h04;
  localparam logic [7:0] TYPE_REPLY      = 8'h06;
  localparam logic [7:0] TYPE_A          = 8'h0A;
  localparam logic [7:0] TYPE_C          = 8'h0C;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_BAD  = 2'd1,
    STATUS_UNKNOWN  = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LEN  = 7'b0000010,
    ST_HDR  = 7'b0000100,
    ST_DATA = 7'b0001000,
    ST_RD   = 7'b0010000,
    ST_LD   = 7'b0100000,
    ST_HOLD = 7'b1000000
  } state_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

  function automatic logic type_known(input logic [7:0] t);
    return (t == TYPE_HOST_READY) || (t == TYPE_2) || (t == TYPE_3) ||
           (t == TYPE_4) || (t == TYPE_REPLY) || (t == TYPE_A) || (t == TYPE_C);
  endfunction

endpackage

[sv/crc8_checked_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_core
// sync/length/crc-8 framed byte receiver with buffered payload result runs
// ----------------------------------------------------------------------------
// Frames arrive one byte per input item: sync 0xFA, length L, crc byte, type,
// then L-2 payload bytes. The payload goes into a small ram and a reflected
// crc-8 (poly 0x8C, init 0) runs over type and payload. While a frame is being
// parsed in_ready stays high, so each byte is taken as it is offered. When a
// frame completes, input stalls and a run of results is produced: one per
// payload byte, or a single one for an empty or too-long payload. Because the
// payload ram has a registered read port, the first result of a run passes
// through states ST_RD and ST_LD after the completing byte, and each further
// result through ST_LD after the previous one is taken. Input is taken again
// in the cycle after the last result is taken. The ram needs no clearing after
// reset: only entries written in the current frame are ever used.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_core
  import crc8fr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_type,
  output logic [1:0] out_status,
  output logic [7:0] out_payload_len,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last,
  output logic       out_reply_needed,
  output logic       out_host_ready
);

  // control state
  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  // frame header / parser registers
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       fcrc_r, fcrc_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             hdr_r, hdr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result run registers
  status_t          run_status_r, run_status_nxt;
  logic [CNT_W-1:0] run_n_r, run_n_nxt;
  logic             run_nopay_r, run_nopay_nxt;
  logic             run_reply_r, run_reply_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;

  // output registers
  logic [7:0] o_type_r, o_type_nxt;
  status_t    o_status_r, o_status_nxt;
  logic [7:0] o_plen_r, o_plen_nxt;
  logic [7:0] o_pbyte_r, o_pbyte_nxt;
  logic [5:0] o_index_r, o_index_nxt;
  logic       o_last_r, o_last_nxt;
  logic       o_reply_r, o_reply_nxt;
  logic       o_host_r, o_host_nxt;

  // payload ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic             in_acc;
  logic [7:0]       plen;
  logic             too_long;
  logic [7:0]       crc_in;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] k_inc;
  logic             fin;
  logic             fin_long;
  logic [7:0]       fin_type;
  status_t          fin_status;

  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_LEN) ||
                    (state_r == ST_HDR) || (state_r == ST_DATA);
  assign in_acc   = in_valid && in_ready;

  // payload length wraps like the length byte does
  assign plen     = len_r - LEN_OVERHEAD;
  assign too_long = (len_r < LEN_OVERHEAD) || (plen > MAX_PLEN);

  // single crc unit: type byte starts from zero, payload bytes chain on
  assign crc_in  = crc_update((state_r == ST_HDR) ? 8'h00 : crc_r, in_rx_byte);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign k_inc   = k_r + CNT_W'(1);

  // read the current entry, or the next one while a result is held
  assign ram_raddr = (state_r == ST_HOLD) ? ADDR_W'(k_inc) : ADDR_W'(k_r);
  assign ram_waddr = ADDR_W'(cnt_r);

  always_comb begin
    state_nxt      = state_r;
    ready_nxt      = ready_r;
    out_valid_nxt  = out_valid_r;
    len_nxt        = len_r;
    fcrc_nxt       = fcrc_r;
    type_nxt       = type_r;
    crc_nxt        = crc_r;
    hdr_nxt        = hdr_r;
    cnt_nxt        = cnt_r;
    run_status_nxt = run_status_r;
    run_n_nxt      = run_n_r;
    run_nopay_nxt  = run_nopay_r;
    run_reply_nxt  = run_reply_r;
    k_nxt          = k_r;
    o_type_nxt     = o_type_r;
    o_status_nxt   = o_status_r;
    o_plen_nxt     = o_plen_r;
    o_pbyte_nxt    = o_pbyte_r;
    o_index_nxt    = o_index_r;
    o_last_nxt     = o_last_r;
    o_reply_nxt    = o_reply_r;
    o_host_nxt     = o_host_r;
    ram_we         = 1'b0;
    fin            = 1'b0;
    fin_long       = 1'b0;
    fin_type       = type_r;

    case (state_r)
      ST_IDLE: begin
        // anything but sync is dropped here
        if (in_acc && (in_rx_byte == SYNC_BYTE)) begin
          state_nxt = ST_LEN;
          hdr_nxt   = 1'b0;
          cnt_nxt   = '0;
          crc_nxt   = 8'h00;
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          len_nxt   = in_rx_byte;
          hdr_nxt   = 1'b0;
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        if (in_acc) begin
          if (!hdr_r) begin
            fcrc_nxt = in_rx_byte;
            hdr_nxt  = 1'b1;
          end else begin
            type_nxt = in_rx_byte;
            crc_nxt  = crc_in;
            fin_type = in_rx_byte;
            if (too_long) begin
              fin      = 1'b1;
              fin_long = 1'b1;
            end else if (plen == 8'h00) begin
              fin = 1'b1;
            end else begin
              cnt_nxt   = '0;
              state_nxt = ST_DATA;
            end
          end
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          ram_we  = 1'b1;
          crc_nxt = crc_in;
          cnt_nxt = cnt_inc;
          if ((8'(cnt_inc) >= plen) || (cnt_inc >= CNT_W'(MAX_PAYLOAD))) begin
            fin = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        o_type_nxt    = type_r;
        o_status_nxt  = run_status_r;
        o_plen_nxt    = plen;
        o_pbyte_nxt   = run_nopay_r ? 8'h00 : ram_rdata;
        o_index_nxt   = 6'(k_r);
        o_last_nxt    = (k_inc == run_n_r);
        o_reply_nxt   = run_reply_r;
        o_host_nxt    = ready_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = ST_LD;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase

    // status priority: too long, crc mismatch, unknown type
    if (fin_long) begin
      fin_status = STATUS_TOO_LONG;
    end else if (crc_in != fcrc_r) begin
      fin_status = STATUS_CRC_BAD;
    end else if (!type_known(fin_type)) begin
      fin_status = STATUS_UNKNOWN;
    end else begin
      fin_status = STATUS_OK;
    end

    // frame complete: start the result run and reset the parser
    if (fin) begin
      run_status_nxt = fin_status;
      run_nopay_nxt  = fin_long || (plen == 8'h00);
      run_n_nxt      = (fin_long || (plen == 8'h00)) ? CNT_W'(1) : CNT_W'(plen);
      run_reply_nxt  = (fin_status == STATUS_OK) && (fin_type == TYPE_REPLY);
      if ((fin_status == STATUS_OK) && (fin_type == TYPE_HOST_READY)) begin
        ready_nxt = 1'b1;
      end
      k_nxt     = '0;
      hdr_nxt   = 1'b0;
      cnt_nxt   = '0;
      crc_nxt   = 8'h00;
      state_nxt = ST_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hdr_r       <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= 8'h00;
      len_r       <= 8'h00;
      fcrc_r      <= 8'h00;
      type_r      <= 8'h00;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      hdr_r       <= hdr_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      fcrc_r      <= fcrc_nxt;
      type_r      <= type_nxt;
    end
  end

  // run and output payload, no reset needed
  always_ff @(posedge clk) begin
    run_status_r <= run_status_nxt;
    run_n_r      <= run_n_nxt;
    run_nopay_r  <= run_nopay_nxt;
    run_reply_r  <= run_reply_nxt;
    k_r          <= k_nxt;
    o_type_r     <= o_type_nxt;
    o_status_r   <= o_status_nxt;
    o_plen_r     <= o_plen_nxt;
    o_pbyte_r    <= o_pbyte_nxt;
    o_index_r    <= o_index_nxt;
    o_last_r     <= o_last_nxt;
    o_reply_r    <= o_reply_nxt;
    o_host_r     <= o_host_nxt;
  end

  // payload buffer; read data is only used while input is stalled
  crc8fr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_frame_type   = o_type_r;
  assign out_status       = o_status_r;
  assign out_payload_len  = o_plen_r;
  assign out_payload_byte = o_pbyte_r;
  assign out_byte_index   = o_index_r;
  assign out_last         = o_last_r;
  assign out_reply_needed = o_reply_r;
  assign out_host_ready   = o_host_r;

`ifndef SYNTHESIS
  // input is stalled for the whole result run
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // parser reopens right after the last item of a run is taken
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("parser not idle after run end");

  // a too-long frame gives a single empty item
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_TOO_LONG)) |->
      (out_last && (out_payload_byte == 8'h00) && (out_byte_index == 6'd0)))
    else $error("too-long result malformed");

  // reply only for good frames
  a_reply_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reply_needed) |->
      ((out_status == STATUS_OK) && (out_frame_type == TYPE_REPLY)))
    else $error("reply flag on a bad frame");
`endif

endmodule

[sv/crc8fr_ram.sv]
// ----------------------------------------------------------------------------
// crc8fr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module crc8fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
